// ===== rtl/crs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and rounding helper for the Catmull-Rom spline evaluator.
// Depends on nothing; used by catmull_rom_spline_eval, crs_checker and tb.

package crs_pkg;

    localparam int COORD_W        = 24;
    localparam int PARAM_W        = 24;
    localparam int FRACTION_BITS  = 16;
    localparam int SEG_W          = PARAM_W - FRACTION_BITS;
    localparam int MAX_POINTS_DEF = 256;

    // Blend weights stay within +/- 2^(FRACTION_BITS+2).
    localparam int QW     = FRACTION_BITS + 4;
    // Multiplier A side: a signed coordinate or a zero-extended fraction.
    localparam int PW     = COORD_W + 1;
    localparam int PROD_W = PW + QW;
    localparam int ACCW   = PROD_W + 3;
    localparam int CNT_W  = 4;

    localparam logic signed [QW-1:0]   TWO_S      = QW'(2) << FRACTION_BITS;
    localparam logic signed [ACCW-1:0] ROUND_BIAS = ACCW'(1) << FRACTION_BITS;
    localparam logic signed [ACCW-1:0] COORD_MAX_A = ACCW'(8388607);
    localparam logic signed [ACCW-1:0] COORD_MIN_A = -ACCW'(8388608);

    typedef enum logic [1:0] {
        OP_RESTART = 2'd0,
        OP_APPEND  = 2'd1,
        OP_EVAL    = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_FEW  = 2'd2,
        ST_PAST = 2'd3
    } status_t;

    typedef struct packed {
        op_t                       op;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [PARAM_W-1:0]        curve_param;
    } req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] result_x;
        logic signed [COORD_W-1:0] result_y;
        status_t                   status;
    } rsp_t;

    // floor((acc + S) / 2S), clipped to the coordinate range.
    function automatic logic signed [COORD_W-1:0] round_sat(
        input logic signed [ACCW-1:0] acc
    );
        logic signed [ACCW-1:0] v;
        logic signed [ACCW-1:0] r;
        v = acc + ROUND_BIAS;
        r = v >>> (FRACTION_BITS + 1);
        if (r > COORD_MAX_A)
            r = COORD_MAX_A;
        else if (r < COORD_MIN_A)
            r = COORD_MIN_A;
        return r[COORD_W-1:0];
    endfunction

endpackage

// ===== rtl/crs_ram.sv =====
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port with registered read data.
// Depends on nothing.

module crs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
)(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/catmull_rom_spline_eval.sv =====
`timescale 1ns / 1ps
// Uniform Catmull-Rom spline evaluator over a RAM of 2D Q16.8 control points: one
// request in, one response out on valid/ready channels. Depends on crs_pkg and crs_ram.
//
// Each request restarts the point table, appends a point, or evaluates the curve at
// curve_param (upper bits pick the segment, the low 16 bits are the local fraction).
// The block handles one request at a time; req_ready is high only while it is idle,
// and it stays high while a finished response waits in the output register. A point
// load, an unused op or an evaluation on a table of fewer than three points goes
// straight to the hand-off state; an evaluation at or past the last point first does
// one RAM read; a full evaluation uses a single 25x20 signed multiplier ten times
// (two passes for the u^2 and u^3 terms, then one product per coordinate of each of
// the four neighbor points) while the four point reads go through the one RAM read port
// in the shadow of the first passes. The table RAM is not cleared after reset: only
// entries below the point count are ever used, and each of those has been written.
// End points repeat the first or last point; results round half up and saturate.

module catmull_rom_spline_eval
    import crs_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_item,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_item
);

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int CMPW = (CW > SEG_W) ? CW : SEG_W;
    localparam int DW   = 2 * COORD_W;

    localparam logic [CW-1:0]    COUNT_FULL = CW'(MAX_POINTS);
    localparam logic [CW-1:0]    COUNT_MIN  = CW'(3);
    localparam logic [CNT_W-1:0] PREP_LAST  = CNT_W'(4);
    localparam logic [CNT_W-1:0] MAC_MULS   = CNT_W'(8);
    localparam logic [CNT_W-1:0] MAC_LAST   = CNT_W'(9);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_MAC  = 5'b00100,
        S_LAST = 5'b01000,
        S_PUT  = 5'b10000
    } state_t;

    // Control state
    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // Datapath registers
    logic [FRACTION_BITS-1:0]   u_reg, u_next;
    logic [AW-1:0]              i_reg, i_next;
    logic [FRACTION_BITS-1:0]   t2_reg, t2_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [QW-1:0]       q_reg [4];
    logic signed [QW-1:0]       q_next [4];
    logic signed [COORD_W-1:0]  px_reg [4];
    logic signed [COORD_W-1:0]  px_next [4];
    logic signed [COORD_W-1:0]  py_reg [4];
    logic signed [COORD_W-1:0]  py_next [4];
    logic signed [ACCW-1:0]     acc_x_reg, acc_x_next;
    logic signed [ACCW-1:0]     acc_y_reg, acc_y_next;
    rsp_t                       res_reg, res_next;
    rsp_t                       rsp_reg, rsp_next;

    // Shared multiplier operands
    logic signed [PW-1:0] mul_a;
    logic signed [QW-1:0] mul_b;

    // Table RAM port
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;

    // Request decode
    logic                     req_fire;
    logic [CMPW-1:0]          seg_ext;
    logic [CMPW-1:0]          last_ext;
    logic [FRACTION_BITS-1:0] u_in;
    logic                     past_end;
    logic                     at_end;
    logic [AW-1:0]            last_idx;

    // Neighbor addresses
    logic [AW-1:0] addr0, addr2, addr3;

    // Weight terms
    logic [FRACTION_BITS-1:0] t3;
    logic signed [QW-1:0]     t2s, t3s, us, t3x3;

    logic [1:0] cap_idx;
    logic [1:0] pt_idx;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    assign seg_ext  = CMPW'(req_item.curve_param[PARAM_W-1:FRACTION_BITS]);
    assign last_ext = CMPW'(count_reg) - CMPW'(1);
    assign u_in     = req_item.curve_param[FRACTION_BITS-1:0];
    assign past_end = (seg_ext > last_ext) || ((seg_ext == last_ext) && (u_in != '0));
    assign at_end   = (seg_ext == last_ext);
    assign last_idx = last_ext[AW-1:0];

    // Clamp the outer neighbors to the first and last point.
    assign addr0 = (i_reg == '0) ? i_reg : i_reg - AW'(1);
    assign addr2 = i_reg + AW'(1);
    assign addr3 = ((CW'(i_reg) + CW'(2)) < count_reg) ? i_reg + AW'(2) : addr2;

    assign t3   = prod_reg[2*FRACTION_BITS-1:FRACTION_BITS];
    assign t2s  = QW'(t2_reg);
    assign t3s  = QW'(t3);
    assign us   = QW'(u_reg);
    assign t3x3 = (t3s <<< 1) + t3s;

    assign cap_idx = 2'(cnt_reg - CNT_W'(1));
    assign pt_idx  = cnt_reg[2:1];

    // One multiplier, registered before any further use
    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_PREP:
            begin
                if (cnt_reg == CNT_W'(0))
                begin
                    mul_a = PW'(u_reg);
                    mul_b = QW'(u_reg);
                end
                else if (cnt_reg == CNT_W'(1))
                begin
                    mul_a = PW'(prod_reg[2*FRACTION_BITS-1:FRACTION_BITS]);
                    mul_b = QW'(u_reg);
                end
            end
            S_MAC:
            begin
                if (cnt_reg < MAC_MULS)
                begin
                    mul_a = cnt_reg[0] ? PW'(py_reg[pt_idx]) : PW'(px_reg[pt_idx]);
                    mul_b = q_reg[pt_idx];
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        u_next         = u_reg;
        i_next         = i_reg;
        t2_next        = t2_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        for (int k = 0; k < 4; k++)
        begin
            q_next[k]  = q_reg[k];
            px_next[k] = px_reg[k];
            py_next[k] = py_reg[k];
        end
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = {req_item.point_x, req_item.point_y};
        rd_addr = last_idx;

        // Drop the response once it has been transferred.
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_next.result_x = '0;
                    res_next.result_y = '0;
                    res_next.status   = ST_OK;
                    state_next        = S_PUT;
                    case (req_item.op)
                        OP_RESTART:
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            count_next = CW'(1);
                        end
                        OP_APPEND:
                        begin
                            if (count_reg == COUNT_FULL)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_EVAL:
                        begin
                            if (count_reg < COUNT_MIN)
                            begin
                                res_next.status = ST_FEW;
                            end
                            else if (past_end || at_end)
                            begin
                                // last point already being read this cycle
                                res_next.status = past_end ? ST_PAST : ST_OK;
                                state_next      = S_LAST;
                            end
                            else
                            begin
                                i_next     = seg_ext[AW-1:0];
                                u_next     = u_in;
                                cnt_next   = '0;
                                state_next = S_PREP;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_OK;
                        end
                    endcase
                end
            end

            S_PREP:
            begin
                // Four reads overlap the u^2 and u^3 multiplier passes.
                case (cnt_reg[1:0])
                    2'd0:    rd_addr = addr0;
                    2'd1:    rd_addr = i_reg;
                    2'd2:    rd_addr = addr2;
                    default: rd_addr = addr3;
                endcase
                if (cnt_reg != '0)
                begin
                    px_next[cap_idx] = rd_data[DW-1:COORD_W];
                    py_next[cap_idx] = rd_data[COORD_W-1:0];
                end
                if (cnt_reg == CNT_W'(1))
                begin
                    t2_next = prod_reg[2*FRACTION_BITS-1:FRACTION_BITS];
                end
                if (cnt_reg == CNT_W'(2))
                begin
                    q_next[0] = -t3s + (t2s <<< 1) - us;
                    q_next[1] = t3x3 - ((t2s <<< 2) + t2s) + TWO_S;
                    q_next[2] = -t3x3 + (t2s <<< 2) + us;
                    q_next[3] = t3s - t2s;
                end
                if (cnt_reg == PREP_LAST)
                begin
                    acc_x_next = '0;
                    acc_y_next = '0;
                    cnt_next   = '0;
                    state_next = S_MAC;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            S_MAC:
            begin
                // Accumulate the product issued one step earlier: x issued on even steps, y on odd.
                if ((cnt_reg != '0) && (cnt_reg <= MAC_MULS))
                begin
                    if (cnt_reg[0])
                        acc_x_next = acc_x_reg + ACCW'(prod_reg);
                    else
                        acc_y_next = acc_y_reg + ACCW'(prod_reg);
                end
                if (cnt_reg == MAC_LAST)
                begin
                    res_next.result_x = round_sat(acc_x_reg);
                    res_next.result_y = round_sat(acc_y_reg);
                    res_next.status   = ST_OK;
                    state_next        = S_PUT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            S_LAST:
            begin
                res_next.result_x = rd_data[DW-1:COORD_W];
                res_next.result_y = rd_data[COORD_W-1:0];
                state_next        = S_PUT;
            end

            S_PUT:
            begin
                // Hold until the output register is free.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg     <= u_next;
        i_reg     <= i_next;
        t2_reg    <= t2_next;
        prod_reg  <= prod_next;
        acc_x_reg <= acc_x_next;
        acc_y_reg <= acc_y_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
        for (int k = 0; k < 4; k++)
        begin
            q_reg[k]  <= q_next[k];
            px_reg[k] <= px_next[k];
            py_reg[k] <= py_next[k];
        end
    end

    crs_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // A response appears only out of the hand-off state.
    a_rsp_from_put: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_PUT))
        else $error("response raised outside hand-off state");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_FULL)
        else $error("point count beyond table depth");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (req_item.op == OP_APPEND) && (count_reg == COUNT_FULL)
        |=> $stable(count_reg) && (res_reg.status == ST_FULL))
        else $error("append to full table changed the count");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (req_item.op == OP_RESTART) |=> count_reg == CW'(1))
        else $error("restart did not leave one point");

    a_mac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> (cnt_reg <= MAC_LAST))
        else $error("multiply-accumulate step counter overran");

endmodule

// ===== sim/crs_checker.sv =====
`timescale 1ns / 1ps
// Response checker for catmull_rom_spline_eval: watches both channels, predicts each
// response from a private copy of the point table and compares it. Depends on crs_pkg.

module crs_checker
    import crs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req_item,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp_item,
    output int   mismatches,
    output int   outstanding
);

    localparam int     TABLE_DEPTH = 256;
    localparam longint UNIT        = longint'(1) << FRACTION_BITS;
    localparam longint SAT_HI      = 64'sd8388607;
    localparam longint SAT_LO      = -64'sd8388608;

    int   pts_x [TABLE_DEPTH];
    int   pts_y [TABLE_DEPTH];
    int   point_total = 0;
    int   rsp_seen    = 0;
    rsp_t curve_expect_q [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: response %0d, %s: got %0d, want %0d",
                 $time, rsp_seen, what, got, want);
        mismatches++;
    endtask

    // 0.5 * acc / S, rounded half up, clipped to Q16.8
    function automatic logic signed [COORD_W-1:0] clip_coord(input longint acc);
        longint v;
        v = (acc + UNIT) >>> (FRACTION_BITS + 1);
        if (v > SAT_HI)
            v = SAT_HI;
        else if (v < SAT_LO)
            v = SAT_LO;
        return v[COORD_W-1:0];
    endfunction

    // Apply one request to the private table and return the response it must give.
    function automatic rsp_t spline_point(input req_t r);
        rsp_t   res;
        longint u, t2, t3, w0, w1, w2, w3;
        int     seg, last, i0, i1, i2, i3;
        res = '0;
        case (r.op)
            OP_RESTART:
            begin
                pts_x[0]    = r.point_x;
                pts_y[0]    = r.point_y;
                point_total = 1;
            end
            OP_APPEND:
            begin
                if (point_total >= TABLE_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    pts_x[point_total] = r.point_x;
                    pts_y[point_total] = r.point_y;
                    point_total++;
                end
            end
            OP_EVAL:
            begin
                seg  = r.curve_param[PARAM_W-1:FRACTION_BITS];
                u    = r.curve_param[FRACTION_BITS-1:0];
                last = point_total - 1;
                if (point_total < 3)
                    res.status = ST_FEW;
                else if (seg >= last)
                begin
                    // at or past the end: hand back the last point
                    res.result_x = COORD_W'(pts_x[last]);
                    res.result_y = COORD_W'(pts_y[last]);
                    if (seg > last || u != 0)
                        res.status = ST_PAST;
                end
                else
                begin
                    i1 = seg;
                    i0 = (seg > 0) ? seg - 1 : seg;
                    i2 = seg + 1;
                    i3 = (seg + 2 < point_total) ? seg + 2 : seg + 1;
                    t2 = (u * u) >>> FRACTION_BITS;
                    t3 = (t2 * u) >>> FRACTION_BITS;
                    w0 = -t3 + 2 * t2 - u;
                    w1 = 3 * t3 - 5 * t2 + 2 * UNIT;
                    w2 = -3 * t3 + 4 * t2 + u;
                    w3 = t3 - t2;
                    res.result_x = clip_coord(pts_x[i0] * w0 + pts_x[i1] * w1
                                            + pts_x[i2] * w2 + pts_x[i3] * w3);
                    res.result_y = clip_coord(pts_y[i0] * w0 + pts_y[i1] * w1
                                            + pts_y[i2] * w2 + pts_y[i3] * w3);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk)
    begin : watch
        rsp_t want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
                curve_expect_q.push_back(spline_point(req_item));
            if (rsp_valid && rsp_ready)
            begin
                rsp_seen++;
                if (curve_expect_q.size() == 0)
                    report_mismatch("response with none pending",
                                    longint'(rsp_item.result_x), 0);
                else
                begin
                    want = curve_expect_q.pop_front();
                    if (rsp_item.result_x !== want.result_x)
                        report_mismatch("result_x", rsp_item.result_x, want.result_x);
                    if (rsp_item.result_y !== want.result_y)
                        report_mismatch("result_y", rsp_item.result_y, want.result_y);
                    if (rsp_item.status !== want.status)
                        report_mismatch("status", rsp_item.status, want.status);
                end
            end
            outstanding <= curve_expect_q.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Top of the catmull_rom_spline_eval testbench: clock, reset, request stimulus, response
// sink and verdict. Depends on crs_pkg, crs_checker and the block itself.

module tb;
    import crs_pkg::*;

    localparam int RANDOM_ITEMS   = 1550;
    localparam int WATCHDOG_LIMIT = 4000;
    // receiver hold-off: starts this many cycles after reset, lasts this long
    localparam int HOLD_START     = 3000;
    localparam int HOLD_CYCLES    = 400;
    // calm window of the random part, in items, with no gaps on either side
    localparam int CALM_FIRST     = 700;
    localparam int CALM_LAST      = 1000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int GAP_PCT        = 26;
    localparam int FULL_TABLE     = 256;

    localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    req_t req_item  = '0;
    logic rsp_ready = 1'b0;
    logic req_ready;
    logic rsp_valid;
    rsp_t rsp_item;

    int   errors;
    int   outstanding;
    logic steady     = 1'b0;
    int   items_sent = 0;
    int   quiet_run  = 0;

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    catmull_rom_spline_eval uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    crs_checker check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_item    (req_item),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_item    (rsp_item),
        .mismatches  (errors),
        .outstanding (outstanding)
    );

    // Watchdog: end the run once no transfer has happened on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_run <= 0;
            else if (quiet_run >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                quiet_run <= quiet_run + 1;
        end
    end

    function automatic req_t make_req(input op_t op, input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y,
                                      input logic [PARAM_W-1:0] param);
        req_t r;
        r.op          = op;
        r.point_x     = x;
        r.point_y     = y;
        r.curve_param = param;
        return r;
    endfunction

    // Full-range values in half the cases, the extremes and small values near zero in the rest.
    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return C_MAX;
            1:       return C_MIN;
            2, 3:    return COORD_W'($urandom_range(0, 4095) - 2048);
            default: return COORD_W'($urandom());
        endcase
    endfunction

    // Curve parameter for a table of n points: mostly inside the curve, some exactly at
    // the last point or just past it, some anywhere at all.
    function automatic logic [PARAM_W-1:0] pick_param(input int n);
        int          pick;
        int          seg;
        logic [15:0] u;
        pick = $urandom_range(0, 99);
        u    = 16'($urandom());
        if ($urandom_range(0, 7) == 0)
            u = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
        if (n < 3 || pick >= 85)
            return PARAM_W'($urandom());
        if (pick >= 70)
        begin
            seg = n - 1;
            if ($urandom_range(0, 1) == 1)
                u = 16'h0000;
        end
        else
            seg = $urandom_range(0, n - 2);
        return {seg[SEG_W-1:0], u};
    endfunction

    // Offer one request and hold it until the block takes it. Idle cycles go in front,
    // except in the calm window.
    task automatic send_req(input req_t r);
        while (!steady && $urandom_range(0, 99) < GAP_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Restart the table, grow it, then evaluate it at several places.
    task automatic run_curve(input int appends, input int evals);
        int n;
        send_req(make_req(OP_RESTART, rand_coord(), rand_coord(), PARAM_W'($urandom())));
        n = 1;
        for (int k = 0; k < appends; k++)
        begin
            send_req(make_req(OP_APPEND, rand_coord(), rand_coord(), PARAM_W'($urandom())));
            if (n < FULL_TABLE)
                n++;
        end
        for (int k = 0; k < evals; k++)
            send_req(make_req(OP_EVAL, rand_coord(), rand_coord(), pick_param(n)));
    endtask

    // Response sink: random back-pressure, one long hold-off early in the run so the
    // block fills up and drops req_ready, and no gaps during the calm window.
    initial
    begin : sink
        int cyc;
        cyc = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc == HOLD_START)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rsp_ready <= steady || ($urandom_range(0, 99) >= GAP_PCT);
        end
    end

    initial
    begin : stimulus
        int start;
        int pick;
        int appends;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, unused op, append on an empty table.
        send_req(make_req(OP_EVAL, 24'sd0, 24'sd0, 24'h000000));
        send_req(make_req(OP_NOP, rand_coord(), rand_coord(), PARAM_W'($urandom())));
        send_req(make_req(OP_APPEND, C_MIN, C_MAX, 24'h000000));
        send_req(make_req(OP_APPEND, 24'sd1, -24'sd1, 24'h000000));
        send_req(make_req(OP_EVAL, 24'sd0, 24'sd0, 24'h000000));
        // Low, high, high, low extremes push the curve above full scale in the middle segment.
        send_req(make_req(OP_RESTART, C_MIN, C_MIN, 24'h000000));
        send_req(make_req(OP_APPEND, C_MAX, C_MAX, 24'h000000));
        send_req(make_req(OP_APPEND, C_MAX, C_MAX, 24'h000000));
        send_req(make_req(OP_APPEND, C_MIN, C_MIN, 24'h000000));
        send_req(make_req(OP_EVAL, 24'sd0, 24'sd0, 24'h018000));
        send_req(make_req(OP_EVAL, 24'sd0, 24'sd0, 24'h000000));
        send_req(make_req(OP_EVAL, 24'sd0, 24'sd0, 24'h00FFFF));
        // last segment repeats the end point as its outer neighbor
        send_req(make_req(OP_EVAL, 24'sd0, 24'sd0, 24'h028000));
        // exactly the last point, then just past it and far past it
        send_req(make_req(OP_EVAL, 24'sd0, 24'sd0, 24'h030000));
        send_req(make_req(OP_EVAL, 24'sd0, 24'sd0, 24'h030001));
        send_req(make_req(OP_EVAL, 24'sd0, 24'sd0, 24'hFFFFFF));
        // Mirrored extremes: x clips low, y clips high.
        send_req(make_req(OP_RESTART, C_MAX, C_MIN, 24'h000000));
        send_req(make_req(OP_APPEND, C_MIN, C_MAX, 24'h000000));
        send_req(make_req(OP_APPEND, C_MIN, C_MAX, 24'h000000));
        send_req(make_req(OP_APPEND, C_MAX, C_MIN, 24'h000000));
        send_req(make_req(OP_EVAL, 24'sd0, 24'sd0, 24'h018000));
        send_req(make_req(OP_NOP, -24'sd1, -24'sd1, 24'hFFFFFF));

        // Random part. The first curve fills the table and keeps appending to a full one.
        start = items_sent;
        run_curve(FULL_TABLE + 4, 24);
        while (items_sent - start < RANDOM_ITEMS)
        begin
            steady <= (items_sent - start >= CALM_FIRST) && (items_sent - start < CALM_LAST);
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                appends = $urandom_range(0, 99);
                if (appends < 5)
                    appends = $urandom_range(0, 1);
                else if (appends < 15)
                    appends = $urandom_range(30, 70);
                else
                    appends = $urandom_range(2, 10);
                run_curve(appends, $urandom_range(2, 12));
            end
            else
                // noise: any op, any fields, on whatever table is there
                send_req(make_req(op_t'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                                  PARAM_W'($urandom())));
        end
        req_valid <= 1'b0;
        steady    <= 1'b0;

        // Drain the responses still owed, then give the block a few more cycles.
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
